@@ hw/rtl/cdq_pkg.sv @@
// Package with the sizes, codes, helper functions and interface types of the circular deque.
package cdq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;

    localparam logic [1:0] CMD_PUSH_REAR  = 2'd0;
    localparam logic [1:0] CMD_POP_REAR   = 2'd1;
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd2;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic accept;
        logic exec;
    } cdq_cmd_t;

    typedef struct packed {
        logic out_free;
    } cdq_stat_t;

    function automatic addr_t next_pos(input addr_t p);
        if (p == addr_t'(DEPTH - 1)) begin
            return '0;
        end
        return p + addr_t'(1);
    endfunction

    function automatic addr_t prev_pos(input addr_t p);
        if (p == '0) begin
            return addr_t'(DEPTH - 1);
        end
        return p - addr_t'(1);
    endfunction

endpackage

@@ hw/rtl/cdq_ctrl.sv @@
// Controller state machine that sequences the accept and execute steps of each item.
module cdq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cdq_pkg::cdq_stat_t stat,
    output cdq_pkg::cdq_cmd_t  ctl
);
    import cdq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign ctl.accept = in_ready && in_valid;
    assign ctl.exec   = (state_reg == S_EXEC) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/cdq_datapath.sv @@
// Datapath with the slot memory, the end pointers, the empty flag and the result register.
module cdq_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  cdq_pkg::cdq_cmd_t  ctl,
    output cdq_pkg::cdq_stat_t stat,
    input  logic [1:0]         cmd,
    input  cdq_pkg::data_t     push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output cdq_pkg::data_t     pop_value,
    output logic [1:0]         status
);
    import cdq_pkg::*;

    data_t mem [DEPTH];

    addr_t      front_reg, front_next;
    addr_t      rear_reg, rear_next;
    logic       empty_reg, empty_next;
    logic       out_valid_reg;
    logic [1:0] cmd_reg;
    data_t      val_reg;
    data_t      rd_data_reg;
    data_t      pop_value_reg, pop_value_next;
    logic [1:0] status_reg, status_next;
    logic       mem_we;
    addr_t      mem_wa;
    addr_t      rd_addr;
    logic       full;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign pop_value     = pop_value_reg;
    assign status        = status_reg;

    assign full    = !empty_reg && (front_reg == next_pos(rear_reg));
    assign rd_addr = (cmd == CMD_POP_REAR) ? rear_reg : front_reg;

    always_comb
    begin
        front_next     = front_reg;
        rear_next      = rear_reg;
        empty_next     = empty_reg;
        pop_value_next = '0;
        status_next    = ST_DONE;
        mem_we         = 1'b0;
        mem_wa         = '0;
        case (cmd_reg)
            CMD_PUSH_REAR, CMD_PUSH_FRONT:
            begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (empty_reg) begin
                    empty_next = 1'b0;
                    front_next = '0;
                    rear_next  = '0;
                    mem_we     = 1'b1;
                    mem_wa     = '0;
                end else if (cmd_reg == CMD_PUSH_REAR) begin
                    rear_next = next_pos(rear_reg);
                    mem_we    = 1'b1;
                    mem_wa    = next_pos(rear_reg);
                end else begin
                    front_next = prev_pos(front_reg);
                    mem_we     = 1'b1;
                    mem_wa     = prev_pos(front_reg);
                end
            end
            default:
            begin
                if (empty_reg) begin
                    status_next = ST_EMPTY;
                end else begin
                    pop_value_next = rd_data_reg;
                    if (front_reg == rear_reg) begin
                        empty_next = 1'b1;
                        front_next = '0;
                        rear_next  = '0;
                    end else if (cmd_reg == CMD_POP_REAR) begin
                        rear_next = prev_pos(rear_reg);
                    end else begin
                        front_next = next_pos(front_reg);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && mem_we) begin
            mem[mem_wa] <= val_reg;
        end
        if (ctl.accept) begin
            rd_data_reg <= mem[rd_addr];
            cmd_reg     <= cmd;
            val_reg     <= push_value;
        end
        if (ctl.exec) begin
            pop_value_reg <= pop_value_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            front_reg     <= '0;
            rear_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.exec) begin
                front_reg     <= front_next;
                rear_reg      <= rear_next;
                empty_reg     <= empty_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/circular_deque.sv @@
// Top level of the circular deque: controller and datapath joined by command and status.
// Each item is taken in the idle state and executed once the output is free;
// its result is registered then, and no new item is taken until that one has executed.
// The slot memory read is registered at acceptance, ahead of the execute step.
// A result that waits at the output holds execution of the next item, not its acceptance.
// Asynchronous active-low reset empties the deque at once; no clearing pass is needed.
module circular_deque (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     cmd,
    input  cdq_pkg::data_t push_value,
    output logic           out_valid,
    input  logic           out_ready,
    output cdq_pkg::data_t pop_value,
    output logic [1:0]     status
);
    import cdq_pkg::*;

    cdq_cmd_t  ctl;
    cdq_stat_t stat;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    cdq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .cmd        (cmd),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status)
    );

endmodule

@@ hw/rtl/cdq_checker.sv @@
// Port-level checker for the circular deque and the bind that attaches it.
module cdq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input cdq_pkg::data_t pop_value,
    input logic [1:0]     status
);
    import cdq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_DONE || status == ST_FULL || status == ST_EMPTY))
        else $error("status code out of range");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> pop_value == '0)
        else $error("refused item carries a value");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken before execution");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_value (pop_value),
    .status    (status)
);
